@@ design/ring_fifo_with_statistics_defines.svh @@
// Assertion macros for the ring FIFO checker.
`ifndef RING_FIFO_WITH_STATISTICS_DEFINES_SVH
`define RING_FIFO_WITH_STATISTICS_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define RFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define RFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rfs_pkg.sv @@
// Shared constants, types and codes of the ring FIFO with statistics.
package rfs_pkg;

    // Built storage depth and the widths that follow from it
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the ports
    localparam int DATA_W = 32;
    localparam int CAP_W  = 11;
    localparam int OCC_W  = 11;
    localparam int OP_W   = 2;

    // Capacity after reset, clamped to the built depth
    localparam int CAP_RESET = 1024;
    localparam logic [CNT_W-1:0] CAP_RESET_EFF =
        CNT_W'((CAP_RESET > DEPTH) ? DEPTH : CAP_RESET);

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_rfs_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic execute;
        logic load_result;
    } t_rfs_cmd;

endpackage

@@ design/rfs_ctrl.sv @@
// Controller state machine: sequences accept, execute and result load.
module rfs_ctrl import rfs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_stall,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_rfs_cmd o_cmd
);

    t_rfs_state r_state;
    t_rfs_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // Output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_in_stall        = 1'b1;
        o_cmd.load_item   = 1'b0;
        o_cmd.execute     = 1'b0;
        o_cmd.load_result = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.load_item = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load_result = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Set output valid on load, drop it once the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/rfs_datapath.sv @@
// Datapath: storage, positions, counters, capacity register and result register.
module rfs_datapath import rfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rfs_cmd          i_cmd,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_capacity_in_use,
    input  logic [OP_W-1:0]   i_op,
    input  logic [DATA_W-1:0] i_value,
    output logic [DATA_W-1:0] o_data_out,
    output logic              o_failed,
    output logic [OCC_W-1:0]  o_occupancy,
    output logic              o_is_empty,
    output logic [DATA_W-1:0] o_push_total,
    output logic [DATA_W-1:0] o_pop_total,
    output logic [OCC_W-1:0]  o_high_water
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  n_cap;
    logic [ADDR_W-1:0] r_head;
    logic [ADDR_W-1:0] r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_peak;
    logic [DATA_W-1:0] r_push_cnt;
    logic [DATA_W-1:0] r_pop_cnt;
    logic              r_rd_ok;
    logic              r_fail;

    logic              is_push;
    logic              is_rd;
    logic              is_full;
    logic              is_emp;
    logic              do_push;
    logic              do_rd;
    logic              do_pop;
    logic [CNT_W-1:0]  head_inc;
    logic [CNT_W-1:0]  tail_inc;
    logic [ADDR_W-1:0] n_head;
    logic [ADDR_W-1:0] n_tail;
    logic [CNT_W-1:0]  count_inc;

    // Clamp the written capacity to the range one to depth
    always_comb begin
        if (i_cfg_capacity_in_use == '0) begin
            n_cap = CNT_W'(1);
        end else if (32'(i_cfg_capacity_in_use) > 32'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = CNT_W'(i_cfg_capacity_in_use);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET_EFF;
        end else if (i_cfg_we) begin
            r_cap <= n_cap;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
    end

    // Decode the operation against the queue state
    assign is_push = (r_op == OP_PUSH);
    assign is_rd   = (r_op == OP_POP) || (r_op == OP_PEEK);
    assign is_full = (r_count >= r_cap);
    assign is_emp  = (r_count == '0);
    assign do_push = is_push && !is_full;
    assign do_rd   = is_rd && !is_emp;
    assign do_pop  = do_rd && (r_op == OP_POP);

    // Advance a position, return to zero at the capacity
    assign head_inc  = CNT_W'(r_head) + CNT_W'(1);
    assign tail_inc  = CNT_W'(r_tail) + CNT_W'(1);
    assign n_head    = (head_inc >= r_cap) ? '0 : ADDR_W'(head_inc);
    assign n_tail    = (tail_inc >= r_cap) ? '0 : ADDR_W'(tail_inc);
    assign count_inc = r_count + CNT_W'(1);

    // Storage write at the tail, registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && do_push) begin
            r_mem[r_tail] <= r_value;
        end
        if (i_cmd.execute && do_rd) begin
            r_rdata <= r_mem[r_head];
        end
    end

    // Update positions, occupancy and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_peak     <= '0;
            r_push_cnt <= '0;
            r_pop_cnt  <= '0;
            r_rd_ok    <= 1'b0;
            r_fail     <= 1'b0;
        end else if (i_cmd.execute) begin
            r_rd_ok <= do_rd;
            r_fail  <= (is_push && is_full) || (is_rd && is_emp);
            if (do_push) begin
                r_tail     <= n_tail;
                r_count    <= count_inc;
                r_push_cnt <= r_push_cnt + DATA_W'(1);
                if (count_inc > r_peak) begin
                    r_peak <= count_inc;
                end
            end
            if (do_pop) begin
                r_head    <= n_head;
                r_count   <= r_count - CNT_W'(1);
                r_pop_cnt <= r_pop_cnt + DATA_W'(1);
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            o_data_out   <= r_rd_ok ? r_rdata : '0;
            o_failed     <= r_fail;
            o_occupancy  <= OCC_W'(r_count);
            o_is_empty   <= (r_count == '0);
            o_push_total <= r_push_cnt;
            o_pop_total  <= r_pop_cnt;
            o_high_water <= OCC_W'(r_peak);
        end
    end

endmodule

@@ design/ring_fifo_with_statistics.sv @@
// Ring FIFO with statistics: top level joining controller and datapath.
// An accepted input beat passes the execute state, then the load state, which waits while a held result is stalled.
// One item at a time: each is accepted, executed on the storage port and loaded before the next is taken.
// The storage read is registered, so pop and peek data appear at the result load.
// Reset (i_rst_n low, synchronous): queue empty, positions and counters zero,
// capacity 1024 clamped to the depth; storage contents are not cleared.
module ring_fifo_with_statistics import rfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_op,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_data_out,
    output logic              o_failed,
    output logic [OCC_W-1:0]  o_occupancy,
    output logic              o_is_empty,
    output logic [DATA_W-1:0] o_push_total,
    output logic [DATA_W-1:0] o_pop_total,
    output logic [OCC_W-1:0]  o_high_water,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CAP_W-1:0]  i_cfg_capacity_in_use
);

    t_rfs_cmd cmd;

    // Capacity writes are taken at any time
    assign o_cfg_ready = 1'b1;

    rfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    rfs_datapath u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_cfg_we              (i_cfg_valid && o_cfg_ready),
        .i_cfg_capacity_in_use (i_cfg_capacity_in_use),
        .i_op                  (i_op),
        .i_value               (i_value),
        .o_data_out            (o_data_out),
        .o_failed              (o_failed),
        .o_occupancy           (o_occupancy),
        .o_is_empty            (o_is_empty),
        .o_push_total          (o_push_total),
        .o_pop_total           (o_pop_total),
        .o_high_water          (o_high_water)
    );

endmodule

@@ design/rfs_checker.sv @@
// Port-level checker of the ring FIFO, bound to the top level.
`include "ring_fifo_with_statistics_defines.svh"

module rfs_checker import rfs_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [OP_W-1:0]   i_op,
    input logic [DATA_W-1:0] i_value,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DATA_W-1:0] o_data_out,
    input logic              o_failed,
    input logic [OCC_W-1:0]  o_occupancy,
    input logic              o_is_empty,
    input logic [DATA_W-1:0] o_push_total,
    input logic [DATA_W-1:0] o_pop_total,
    input logic [OCC_W-1:0]  o_high_water,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [CAP_W-1:0]  i_cfg_capacity_in_use
);

    // A stalled result beat holds its payload
    `RFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_data_out) && $stable(o_occupancy) && $stable(o_push_total), "stalled result changed")

    // Empty flag agrees with occupancy
    `RFS_ASSERT_SAME(a_empty_flag, i_clk, i_rst_n, o_out_valid, o_is_empty == (o_occupancy == '0), "empty flag disagrees with occupancy")

    // Occupancy never exceeds the high-water mark
    `RFS_ASSERT_SAME(a_high_water, i_clk, i_rst_n, o_out_valid, o_occupancy <= o_high_water, "occupancy above high-water mark")

    // A failed operation returns zero data
    `RFS_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_failed, o_data_out == '0, "failed beat carries data")

    // An accepted item keeps the input stalled while it is worked on
    `RFS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accept")

endmodule

bind ring_fifo_with_statistics rfs_checker u_rfs_checker (.*);
